// File: src/complex_matrix_multiply_accumulate_macros.svh
// Assertion macros used by the matrix multiply-accumulate top level
`ifndef COMPLEX_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define COMPLEX_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
// Implication checked every clock, disabled during reset
`define CMMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define CMMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: src/cmma_pkg.sv
// Package: shared types and constants of the complex matrix multiply-accumulate
`timescale 1ns / 1ps
package cmma_pkg;
	localparam int IDX_W = 3;
	localparam int COMP_W = 32;

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_LOAD_C = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_SET = 2'd0,
		MODE_ADD = 2'd1,
		MODE_SUB = 2'd2,
		MODE_RSV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	// per-step control from sequencer to datapath
	typedef struct packed {
		logic       first;
		logic       last_k;
		logic       valid;
	} step_ctl_t;
endpackage

// File: src/cmma_mem.sv
// Memory: synchronous one-read one-write element store
`timescale 1ns / 1ps
module cmma_mem #(
	parameter int DEPTH = 9,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: src/cmma_mac.sv
// Datapath: complex multiply, wide accumulate, scale and saturate
`timescale 1ns / 1ps
module cmma_mac #(
	parameter int FRAC_BITS = 23
) (
	input  logic               clk,
	input  cmma_pkg::step_ctl_t ctl,
	input  logic [1:0]         mode,
	input  logic [63:0]        a_word,
	input  logic [63:0]        b_word,
	input  logic [63:0]        c_word,
	output logic               res_valid,
	output logic [31:0]        res_re,
	output logic [31:0]        res_im,
	input  logic               arst_n
);
	import cmma_pkg::*;
	localparam int ACC_W = 64 + FRAC_BITS + 8;

	logic signed [63:0] rr_s1, ii_s1, ri_s1, ir_s1;
	logic               v_s1, first_s1, lastk_s1;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0] st_re, st_im, base_re, base_im, nx_re, nx_im;
	logic               sub, acc_mode, done_q;

	// stage 1: four products
	always_ff @(posedge clk) begin
		rr_s1 <= $signed(a_word[31:0]) * $signed(b_word[31:0]);
		ii_s1 <= $signed(a_word[63:32]) * $signed(b_word[63:32]);
		ri_s1 <= $signed(a_word[31:0]) * $signed(b_word[63:32]);
		ir_s1 <= $signed(a_word[63:32]) * $signed(b_word[31:0]);
		first_s1 <= ctl.first;
		lastk_s1 <= ctl.last_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= ctl.valid;
			done_q <= v_s1 && lastk_s1;
		end
	end

	assign sub = (mode == MODE_SUB);
	assign acc_mode = (mode == MODE_ADD) || sub;

	// starting value from C (c_word is stable across the element)
	always_comb begin
		st_re = ACC_W'($signed(c_word[31:0])) <<< FRAC_BITS;
		st_im = ACC_W'($signed(c_word[63:32])) <<< FRAC_BITS;
		if (!acc_mode) begin
			st_re = '0;
			st_im = '0;
		end
		base_re = first_s1 ? st_re : acc_re_q;
		base_im = first_s1 ? st_im : acc_im_q;
		if (sub) begin
			nx_re = base_re - ACC_W'(rr_s1) + ACC_W'(ii_s1);
			nx_im = base_im - ACC_W'(ir_s1) - ACC_W'(ri_s1);
		end else begin
			nx_re = base_re + ACC_W'(rr_s1) - ACC_W'(ii_s1);
			nx_im = base_im + ACC_W'(ir_s1) + ACC_W'(ri_s1);
		end
	end

	// stage 2: accumulator
	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_re_q <= nx_re;
			acc_im_q <= nx_im;
		end
	end

	function automatic logic [31:0] scale_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] s;
		s = v >>> FRAC_BITS;
		if (s > ACC_W'(64'sh7FFFFFFF)) scale_sat = 32'h7FFFFFFF;
		else if (s < -ACC_W'(64'sh80000000)) scale_sat = 32'h80000000;
		else scale_sat = s[31:0];
	endfunction

	assign res_valid = done_q;
	assign res_re = scale_sat(acc_re_q);
	assign res_im = scale_sat(acc_im_q);
endmodule

// File: src/complex_matrix_multiply_accumulate.sv
// Top level: complex matrix multiply-accumulate over three element memories
// A run issues one MAC step per cycle through the multiply stage for each element,
// then a write-back to C and the output.
// Each result word waits in an output register until taken; intake is held during a run.
// The k loop over one memory port sets rate; no new element starts until the word is taken.
// Reset clears control state only; matrix memories are undefined until written.
`timescale 1ns / 1ps
module complex_matrix_multiply_accumulate #(
	parameter int DIM = 3,
	parameter int FRAC_BITS = 23
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [2:0]  row,
	input  logic [2:0]  col,
	input  logic [31:0] re_part,
	input  logic [31:0] im_part,
	input  logic [1:0]  mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_row,
	output logic [2:0]  out_col,
	output logic [31:0] out_re,
	output logic [31:0] out_im,
	output logic        last
);
	import cmma_pkg::*;
	`include "complex_matrix_multiply_accumulate_macros.svh"

	localparam int DEPTH = DIM * DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;

	state_t state_q, state_d;
	logic [KW-1:0] i_q, j_q, k_q;
	logic [1:0] mode_q;
	logic issuing_q;
	logic accept;
	logic ld_ok;
	logic [AW-1:0] ld_addr, a_ra, b_ra, c_addr;
	logic [63:0] a_rd, b_rd, c_rd, c_wd;
	logic we_a, we_b, we_c;
	step_ctl_t ctl;
	logic res_valid;
	logic [31:0] res_re, res_im;
	logic first_step, lastk_step;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign ld_ok = (32'(row) < DIM) && (32'(col) < DIM);
	assign ld_addr = AW'(32'(row) * DIM + 32'(col));
	assign c_addr = AW'(32'(i_q) * DIM + 32'(j_q));
	assign a_ra = AW'(32'(i_q) * DIM + 32'(k_q));
	assign b_ra = AW'(32'(k_q) * DIM + 32'(j_q));

	// memory writes
	assign we_a = accept && (op == OP_LOAD_A) && ld_ok;
	assign we_b = accept && (op == OP_LOAD_B) && ld_ok;
	assign we_c = (accept && (op == OP_LOAD_C) && ld_ok) || (res_valid);
	assign c_wd = res_valid ? {res_im, res_re} : {im_part, re_part};

	cmma_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_a (
		.clk(clk), .we(we_a), .waddr(ld_addr), .wdata({im_part, re_part}),
		.raddr(a_ra), .rdata(a_rd));
	cmma_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_b (
		.clk(clk), .we(we_b), .waddr(ld_addr), .wdata({im_part, re_part}),
		.raddr(b_ra), .rdata(b_rd));
	cmma_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_c (
		.clk(clk), .we(we_c), .waddr(res_valid ? c_addr : ld_addr), .wdata(c_wd),
		.raddr(c_addr), .rdata(c_rd));

	// step control is registered to line up with the registered memory read
	assign first_step = (k_q == '0);
	assign lastk_step = (32'(k_q) == DIM - 1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl <= '0;
		end else begin
			ctl.valid <= issuing_q;
			ctl.first <= first_step;
			ctl.last_k <= lastk_step;
		end
	end

	cmma_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk(clk), .ctl(ctl), .mode(mode_q), .a_word(a_rd), .b_word(b_rd),
		.c_word(c_rd), .res_valid(res_valid), .res_re(res_re), .res_im(res_im),
		.arst_n(arst_n));

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && op == OP_RUN) state_d = ST_RUN;
			ST_RUN:  if (res_valid) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) begin
					if (last) state_d = ST_IDLE;
					else state_d = ST_RUN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// index counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0; j_q <= '0; k_q <= '0;
			mode_q <= MODE_SET; issuing_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && accept && op == OP_RUN) begin
				i_q <= '0; j_q <= '0; k_q <= '0;
				mode_q <= mode; issuing_q <= 1'b1;
			end else if (issuing_q) begin
				if (lastk_step) issuing_q <= 1'b0;
				else k_q <= k_q + 1'b1;
			end
			if (res_valid) out_valid <= 1'b1;
			if (state_q == ST_OUT && !out_stall) begin
				out_valid <= 1'b0;
				k_q <= '0;
				if (!last) begin
					issuing_q <= 1'b1;
					if (32'(j_q) == DIM - 1) begin
						j_q <= '0; i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_re <= res_re;
			out_im <= res_im;
			out_row <= 3'(i_q);
			out_col <= 3'(j_q);
			last <= (32'(i_q) == DIM - 1) && (32'(j_q) == DIM - 1);
		end
	end

	`CMMA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !accept, "accept while busy")
	`CMMA_ASSERT_IMP(a_out_only_out, clk, arst_n, out_valid, state_q == ST_OUT, "output outside out state")
	`CMMA_ASSERT_NXT(a_res_to_out, clk, arst_n, res_valid, out_valid, "result not registered")
	`CMMA_ASSERT_IMP(a_no_issue_out, clk, arst_n, out_valid, !issuing_q && !res_valid, "issue during output")
endmodule
